@@ hdl/swa_pkg.sv @@
`default_nettype none

package swa_pkg;

   localparam int Q_FRAC     = 8;
   localparam int CFG_BITS   = 7;
   localparam int COUNT_BITS = 7;

endpackage

`default_nettype wire

@@ hdl/swa_if.sv @@
`default_nettype none

interface swa_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          sample_invalid;

   modport source (output valid, output sample, output sample_invalid, input ready);
   modport sink   (input valid, input sample, input sample_invalid, output ready);
endinterface

interface swa_rsp_if #(
   parameter int SAMPLE_BITS = 16
);
   import swa_pkg::*;

   logic                                 valid;
   logic                                 ready;
   logic signed [SAMPLE_BITS+Q_FRAC-1:0] average_q8;
   logic        [COUNT_BITS-1:0]         fill_count;

   modport source (output valid, output average_q8, output fill_count, input ready);
   modport sink   (input valid, input average_q8, input fill_count, output ready);
endinterface

`default_nettype wire

@@ hdl/swa_ram.sv @@
`default_nettype none

module swa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ hdl/sliding_window_average_top.sv @@
// Boxcar moving average over the last window_size signed samples, reported as a signed
// mean with 8 fractional bits (truncated toward zero) plus the number of samples held.
// An item flagged invalid leaves the window alone and just reports the current mean.
// Writing the window size while idle (0 is taken as 1, values above WINDOW_MAX saturate)
// empties the window; a write while busy is ignored. The block handles one item at a time
// and drops req ready while busy or while the window size is being written. A valid item
// that finds the window full first fetches the oldest sample from the sample RAM and
// takes it off the running sum, and every valid item then adds its sample to the sum.
// Every item, valid or not, then sets up the divide, runs the bit-serial restoring
// divider (one quotient bit per cycle), which an empty window skips with a mean of 0,
// and loads the result register. The result register lets the next item be accepted
// while the previous result still waits on rsp ready; the load of the next result
// waits until that one has gone.
`default_nettype none

module sliding_window_average_top #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   swa_req_if.sink                           req_chan,
   swa_rsp_if.source                         rsp_chan,
   input  wire logic                         csr_wr_en,
   input  wire logic [swa_pkg::CFG_BITS-1:0] csr_wr_data
);

   import swa_pkg::*;

   localparam int PTR_W  = $clog2(WINDOW_MAX);
   localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
   localparam int SUM_W  = SAMPLE_BITS + PTR_W;
   localparam int MAG_W  = SUM_W + Q_FRAC;
   localparam int AVG_W  = SAMPLE_BITS + Q_FRAC;
   localparam int STEP_W = $clog2(MAG_W + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SUB,
      S_ADD,
      S_DIV_INIT,
      S_DIV,
      S_FIN
   } state_type;

   state_type               state_ff, state_in;
   logic [PTR_W-1:0]        oldest_ff, oldest_in;
   logic [PTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic [CNT_W-1:0]        window_ff, window_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SAMPLE_BITS-1:0]  sample_ff, sample_in;
   logic                    neg_ff, neg_in;
   logic [MAG_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [AVG_W-1:0]        rsp_avg_ff, rsp_avg_in;
   logic [COUNT_BITS-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                    accept;
   logic                    ram_wr_en;
   logic [SAMPLE_BITS-1:0]  ram_rd_data;
   logic signed [SUM_W-1:0] addend;
   logic [SUM_W-1:0]        abs_sum;
   logic [CNT_W+1:0]        trial;
   logic [MAG_W-1:0]        signed_quo;
   logic [CNT_W-1:0]        cfg_window;

   assign accept          = req_chan.valid && req_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE) && !csr_wr_en;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.average_q8 = rsp_avg_ff;
   assign rsp_chan.fill_count = rsp_cnt_ff;
   assign ram_wr_en       = (state_ff == S_ADD);

   swa_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (WINDOW_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (oldest_ff),
      .rd_data (ram_rd_data)
   );

   function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] win);
      logic [CNT_W:0] n;
      n = (CNT_W+1)'(p) + 1'b1;
      return (n >= {1'b0, win}) ? '0 : PTR_W'(n);
   endfunction

   always_comb begin
      if (int'(csr_wr_data) < 1) begin
         cfg_window = CNT_W'(1);
      end else if (int'(csr_wr_data) > WINDOW_MAX) begin
         cfg_window = CNT_W'(WINDOW_MAX);
      end else begin
         cfg_window = CNT_W'(csr_wr_data);
      end
   end

   // One adder serves both the removal of the oldest sample and the addition of the new one.
   always_comb begin
      if (state_ff == S_SUB) begin
         addend = -SUM_W'(signed'(ram_rd_data));
      end else begin
         addend = SUM_W'(signed'(sample_ff));
      end
   end

   assign abs_sum    = sum_ff[SUM_W-1] ? (~sum_ff + 1'b1) : sum_ff;
   assign trial      = {1'b0, rem_ff, quo_ff[MAG_W-1]} - {2'b00, held_ff};
   assign signed_quo = neg_ff ? (~quo_ff + 1'b1) : quo_ff;

   always_comb begin
      state_in     = state_ff;
      oldest_in    = oldest_ff;
      wr_ptr_in    = wr_ptr_ff;
      held_in      = held_ff;
      window_in    = window_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_avg_in   = rsp_avg_ff;
      rsp_cnt_in   = rsp_cnt_ff;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (csr_wr_en) begin
               window_in = cfg_window;
               oldest_in = '0;
               wr_ptr_in = '0;
               held_in   = '0;
               sum_in    = '0;
            end else if (accept) begin
               sample_in = req_chan.sample;
               if (req_chan.sample_invalid) begin
                  state_in = S_DIV_INIT;
               end else if (held_ff >= window_ff) begin
                  state_in = S_SUB;
               end else begin
                  state_in = S_ADD;
               end
            end
         end
         S_SUB: begin
            sum_in    = sum_ff + addend;
            oldest_in = advance(oldest_ff, window_ff);
            held_in   = held_ff - 1'b1;
            state_in  = S_ADD;
         end
         S_ADD: begin
            sum_in    = sum_ff + addend;
            wr_ptr_in = advance(wr_ptr_ff, window_ff);
            held_in   = held_ff + 1'b1;
            state_in  = S_DIV_INIT;
         end
         S_DIV_INIT: begin
            neg_in  = sum_ff[SUM_W-1];
            quo_in  = {abs_sum, {Q_FRAC{1'b0}}};
            rem_in  = '0;
            step_in = STEP_W'(MAG_W - 1);
            if (held_ff == '0) begin
               quo_in   = '0;
               state_in = S_FIN;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[CNT_W+1]) begin
               rem_in = trial[CNT_W-1:0];
               quo_in = {quo_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[CNT_W-2:0], quo_ff[MAG_W-1]};
               quo_in = {quo_ff[MAG_W-2:0], 1'b0};
            end
            step_in = step_ff - 1'b1;
            if (step_ff == '0) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = signed_quo[AVG_W-1:0];
               rsp_cnt_in   = COUNT_BITS'(held_ff);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         oldest_ff    <= '0;
         wr_ptr_ff    <= '0;
         held_ff      <= '0;
         window_ff    <= CNT_W'(WINDOW_MAX);
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         wr_ptr_ff    <= wr_ptr_in;
         held_ff      <= held_in;
         window_ff    <= window_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      neg_ff     <= neg_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      step_ff    <= step_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

`ifndef SYNTH
   a_held_in_window: assert property (@(posedge clock) disable iff (reset)
      held_ff <= window_ff)
      else $error("fill count exceeds window size");

   a_empty_sum_zero: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> (sum_ff == '0))
      else $error("empty window with nonzero running sum");

   a_ptrs_in_window: assert property (@(posedge clock) disable iff (reset)
      ((CNT_W+1)'(wr_ptr_ff) < {1'b0, window_ff}) &&
      ((CNT_W+1)'(oldest_ff) < {1'b0, window_ff}))
      else $error("ring pointer outside window");

   a_full_window_reads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUB) |-> $past(held_ff >= window_ff))
      else $error("oldest sample removed from a window that was not full");
`endif

endmodule

`default_nettype wire
